// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the block's RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/gls_pkg.sv
// ---------------------------------------------------------------------------
// gls_pkg
// Widths, codes, types and helpers of the SGD pair-update block.
// ---------------------------------------------------------------------------
package gls_pkg;

  localparam int NODE_DEPTH  = 1024;
  localparam int COORD_WIDTH = 48;

  localparam int AW    = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int IDW   = 10;
  localparam int POSW  = 32;
  localparam int ETAW  = 40;
  localparam int MODEW = 2;

  localparam int OFF_NB  = IDW;
  localparam int OFF_PA  = 2 * IDW;
  localparam int OFF_PB  = OFF_PA + POSW;
  localparam int OFF_ETA = OFF_PB + POSW;
  localparam int OFF_XIN = OFF_ETA + ETAW;
  localparam int OFF_YIN = OFF_XIN + COORD_WIDTH;
  localparam int ITW_RAW = OFF_YIN + COORD_WIDTH;
  localparam int ITW     = ((ITW_RAW + 7) / 8) * 8;
  localparam int OTW     = ((4 * COORD_WIDTH + 7) / 8) * 8;
  localparam int MEMW    = 2 * COORD_WIDTH;

  // arithmetic unit widths
  localparam int OPW   = (COORD_WIDTH + 1 > 49) ? COORD_WIDTH + 1 : 49;
  localparam int QW    = OPW - 1;
  localparam int PW    = 2 * OPW;
  localparam int DIGW  = 16;
  localparam int MD    = (OPW + DIGW - 1) / DIGW;
  localparam int BW    = MD * DIGW;
  localparam int CNTW  = $clog2(PW + 1);
  localparam int SRW   = OPW + 3;
  localparam int MUQW  = 32;
  localparam int MUW   = MUQW + 1;
  localparam int ETA_SHIFT = 24;
  localparam int DIST_SHIFT = 16;
  localparam int MAG_SHIFT = 33;

  localparam logic [MODEW-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODEW-1:0] MODE_UPDATE = 2'd1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [1:0] {
    ALU_MUL    = 2'd0,
    ALU_DIV_MU = 2'd1,
    ALU_DIV_CO = 2'd2,
    ALU_SQRT   = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  // node index modulo NODE_DEPTH by restoring subtraction
  function automatic logic [AW-1:0] gls_index(input logic [IDW-1:0] v);
    int r;
    r = int'(v);
    for (int k = IDW - 1; k >= 0; k--) begin
      if (r >= (NODE_DEPTH << k)) begin
        r = r - (NODE_DEPTH << k);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [COORD_WIDTH-1:0] gls_absdiff(input coord_t a, input coord_t b);
    logic signed [COORD_WIDTH:0] t;
    logic [COORD_WIDTH:0] m;
    t = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    m = t[COORD_WIDTH] ? $unsigned(-t) : $unsigned(t);
    if (COORD_WIDTH == 64 && m[COORD_WIDTH-1]) begin
      m = {2'b00, {(COORD_WIDTH-1){1'b1}}};
    end
    return m[COORD_WIDTH-1:0];
  endfunction

  // c + mag or c - mag, saturated to the coordinate range
  function automatic coord_t gls_sat_add(input coord_t c, input logic [QW-1:0] mag,
                                         input logic sub);
    logic signed [QW+1:0] ce;
    logic signed [QW+1:0] me;
    logic signed [QW+1:0] s;
    logic signed [QW+1:0] hi;
    logic signed [QW+1:0] lo;
    ce = $signed({{(QW+2-COORD_WIDTH){c[COORD_WIDTH-1]}}, c});
    me = $signed({2'b00, mag});
    hi = $signed({{(QW+3-COORD_WIDTH){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    lo = $signed({{(QW+3-COORD_WIDTH){1'b1}}, {(COORD_WIDTH-1){1'b0}}});
    s  = sub ? (ce - me) : (ce + me);
    if (s > hi) begin
      s = hi;
    end else if (s < lo) begin
      s = lo;
    end
    return s[COORD_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/core/graph_layout_sgd_pair_update.sv
// ---------------------------------------------------------------------------
// graph_layout_sgd_pair_update
// Pair-update engine for path-guided SGD graph layout.
// ---------------------------------------------------------------------------
// One beat is taken at a time; in_tready is high only while the engine is
// idle. A write beat stores its node, then reads both nodes back as a read
// beat does; an update beat also moves the pair, with a step-size division
// if needed: one shared iterative unit does every multiply (16 bits a cycle),
// the square root (one root bit a cycle, 49 steps) and the divisions (one
// quotient bit a cycle, 48 steps for each coordinate, 32 for the step size),
// and the node memory has a single read and a single write port. The result
// beat sits in an output register, so the engine stalls only when a second
// result is ready before the first has been taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module graph_layout_sgd_pair_update (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // node_a, node_b, pos_a, pos_b, eta, x_in, y_in
  input  logic [gls_pkg::ITW-1:0]      in_tdata,
  // mode
  input  logic [gls_pkg::MODEW-1:0]    in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // x_a, y_a, x_b, y_b
  output logic [gls_pkg::OTW-1:0]      out_tdata
);
  import gls_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_WR0  = 11'b00000000010,
    S_RA   = 11'b00000000100,
    S_RB   = 11'b00000001000,
    S_CB   = 11'b00000010000,
    S_PREP = 11'b00000100000,
    S_GO   = 11'b00001000000,
    S_WAIT = 11'b00010000000,
    S_WA   = 11'b00100000000,
    S_WB   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  typedef enum logic [8:0] {
    ST_MU   = 9'b000000001,
    ST_SQX  = 9'b000000010,
    ST_SQY  = 9'b000000100,
    ST_SQRT = 9'b000001000,
    ST_MUM  = 9'b000010000,
    ST_MX   = 9'b000100000,
    ST_DX   = 9'b001000000,
    ST_MY   = 9'b010000000,
    ST_DY   = 9'b100000000
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   final_r, final_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [OTW-1:0] out_data_r, out_data_nxt;

  logic [AW-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [POSW-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [ETAW-1:0] eta_r, eta_nxt;
  coord_t          xin_r, xin_nxt, yin_r, yin_nxt;
  coord_t          xa_r, xa_nxt, ya_r, ya_nxt, xb_r, xb_nxt, yb_r, yb_nxt;

  logic [POSW-1:0]        d_r, d_nxt;
  logic [MUW-1:0]         mu_r, mu_nxt;
  logic [COORD_WIDTH-1:0] dxm_r, dxm_nxt, dym_r, dym_nxt;
  logic                   dxneg_r, dxneg_nxt, dyneg_r, dyneg_nxt, dneg_r, dneg_nxt;
  logic [PW-1:0]          tmp_r, tmp_nxt;
  logic [OPW-1:0]         mag_r, mag_nxt, m_r, m_nxt;
  logic [QW-1:0]          dmag_r, dmag_nxt, mxm_r, mxm_nxt, mym_r, mym_nxt;

  logic [POSW-1:0]        d_c;
  logic                   mu_sat;
  logic [COORD_WIDTH-1:0] dxa_c, dya_c;
  logic [OPW-1:0]         bigd;
  logic                   mxneg, myneg;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [OPW-1:0]    alu_a, alu_b, alu_den;
  logic [PW-1:0]     alu_num, alu_res;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [MEMW-1:0]   mem_wdata, mem_rdata;

  gls_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_a),
    .opb   (alu_b),
    .num   (alu_num),
    .den   (alu_den),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  gls_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign d_c    = (pa_r >= pb_r) ? (pa_r - pb_r) : (pb_r - pa_r);
  assign mu_sat = (d_c == '0) || (eta_r >= {d_c, 8'b0});
  assign dxa_c  = gls_absdiff(xa_r, xb_r);
  assign dya_c  = gls_absdiff(ya_r, yb_r);
  assign bigd   = OPW'({d_r, {DIST_SHIFT{1'b0}}});
  assign mxneg  = dneg_r ^ dxneg_r;
  assign myneg  = dneg_r ^ dyneg_r;

  assign mem_raddr = (state_r == S_RA) ? a_r : b_r;

  // shared unit operands
  always_comb begin
    alu_req.start = (state_r == S_GO);
    alu_req.op    = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    alu_num       = tmp_r;
    alu_den       = mag_r;
    unique case (step_r)
      ST_MU: begin
        alu_req.op = ALU_DIV_MU;
        alu_num    = PW'({eta_r, {ETA_SHIFT{1'b0}}});
        alu_den    = OPW'(d_r);
      end
      ST_SQX: begin
        alu_a = OPW'(dxm_r);
        alu_b = OPW'(dxm_r);
      end
      ST_SQY: begin
        alu_a = OPW'(dym_r);
        alu_b = OPW'(dym_r);
      end
      ST_SQRT: alu_req.op = ALU_SQRT;
      ST_MUM: begin
        alu_a = m_r;
        alu_b = OPW'(mu_r);
      end
      ST_MX: begin
        alu_a = OPW'(dmag_r);
        alu_b = OPW'(dxm_r);
      end
      ST_DX: alu_req.op = ALU_DIV_CO;
      ST_MY: begin
        alu_a = OPW'(dmag_r);
        alu_b = OPW'(dym_r);
      end
      ST_DY: alu_req.op = ALU_DIV_CO;
      default: alu_req.op = ALU_MUL;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    a_nxt = a_r;   b_nxt = b_r;
    pa_nxt = pa_r; pb_nxt = pb_r;
    eta_nxt = eta_r;
    xin_nxt = xin_r; yin_nxt = yin_r;
    xa_nxt = xa_r; ya_nxt = ya_r; xb_nxt = xb_r; yb_nxt = yb_r;
    d_nxt = d_r;   mu_nxt = mu_r;
    dxm_nxt = dxm_r; dym_nxt = dym_r;
    dxneg_nxt = dxneg_r; dyneg_nxt = dyneg_r; dneg_nxt = dneg_r;
    tmp_nxt = tmp_r; mag_nxt = mag_r; m_nxt = m_r;
    dmag_nxt = dmag_r; mxm_nxt = mxm_r; mym_nxt = mym_r;
    mem_we    = 1'b0;
    mem_waddr = a_r;
    mem_wdata = {yin_r, xin_r};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          a_nxt   = gls_index(in_tdata[IDW-1:0]);
          b_nxt   = gls_index(in_tdata[OFF_NB +: IDW]);
          pa_nxt  = in_tdata[OFF_PA +: POSW];
          pb_nxt  = in_tdata[OFF_PB +: POSW];
          eta_nxt = in_tdata[OFF_ETA +: ETAW];
          xin_nxt = in_tdata[OFF_XIN +: COORD_WIDTH];
          yin_nxt = in_tdata[OFF_YIN +: COORD_WIDTH];
          final_nxt = (in_tuser != MODE_UPDATE);
          state_nxt = (in_tuser == MODE_WRITE) ? S_WR0 : S_RA;
        end
      end
      S_WR0: begin
        mem_we    = 1'b1;
        state_nxt = S_RA;
      end
      S_RA: state_nxt = S_RB;
      S_RB: begin
        xa_nxt    = mem_rdata[COORD_WIDTH-1:0];
        ya_nxt    = mem_rdata[MEMW-1:COORD_WIDTH];
        state_nxt = S_CB;
      end
      S_CB: begin
        xb_nxt    = mem_rdata[COORD_WIDTH-1:0];
        yb_nxt    = mem_rdata[MEMW-1:COORD_WIDTH];
        state_nxt = final_r ? S_OUT : S_PREP;
      end
      S_PREP: begin
        d_nxt     = d_c;
        mu_nxt    = {1'b1, {MUQW{1'b0}}};
        dxneg_nxt = (xa_r < xb_r);
        dyneg_nxt = (ya_r < yb_r);
        dxm_nxt   = dxa_c;
        dym_nxt   = dya_c;
        if (dxa_c == '0) begin
          dxm_nxt   = COORD_WIDTH'(1);
          dxneg_nxt = 1'b0;
        end
        step_nxt  = mu_sat ? ST_SQX : ST_MU;
        state_nxt = S_GO;
      end
      S_GO: state_nxt = S_WAIT;
      S_WAIT: begin
        if (alu_rsp.done) begin
          state_nxt = S_GO;
          unique case (step_r)
            ST_MU: begin
              mu_nxt   = {1'b0, alu_res[MUQW-1:0]};
              step_nxt = ST_SQX;
            end
            ST_SQX: begin
              tmp_nxt  = alu_res;
              step_nxt = ST_SQY;
            end
            ST_SQY: begin
              tmp_nxt  = tmp_r + alu_res;
              step_nxt = ST_SQRT;
            end
            ST_SQRT: begin
              mag_nxt = alu_res[OPW-1:0];
              if (alu_res[OPW-1:0] >= bigd) begin
                m_nxt    = alu_res[OPW-1:0] - bigd;
                dneg_nxt = 1'b0;
              end else begin
                m_nxt    = bigd - alu_res[OPW-1:0];
                dneg_nxt = 1'b1;
              end
              step_nxt = ST_MUM;
            end
            ST_MUM: begin
              dmag_nxt = alu_res[MAG_SHIFT +: QW];
              step_nxt = ST_MX;
            end
            ST_MX: begin
              tmp_nxt  = alu_res;
              step_nxt = ST_DX;
            end
            ST_DX: begin
              mxm_nxt  = alu_res[QW-1:0];
              step_nxt = ST_MY;
            end
            ST_MY: begin
              tmp_nxt  = alu_res;
              step_nxt = ST_DY;
            end
            ST_DY: begin
              mym_nxt   = alu_res[QW-1:0];
              state_nxt = S_WA;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WA: begin
        mem_we    = 1'b1;
        mem_waddr = a_r;
        mem_wdata = {gls_sat_add(ya_r, mym_r, !myneg), gls_sat_add(xa_r, mxm_r, !mxneg)};
        state_nxt = S_WB;
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = b_r;
        mem_wdata = {gls_sat_add(yb_r, mym_r, myneg), gls_sat_add(xb_r, mxm_r, mxneg)};
        final_nxt = 1'b1;
        state_nxt = S_RA;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OTW'({yb_r, xb_r, ya_r, xa_r});
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_SQX;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    a_r <= a_nxt;     b_r <= b_nxt;
    pa_r <= pa_nxt;   pb_r <= pb_nxt;
    eta_r <= eta_nxt;
    xin_r <= xin_nxt; yin_r <= yin_nxt;
    xa_r <= xa_nxt;   ya_r <= ya_nxt;
    xb_r <= xb_nxt;   yb_r <= yb_nxt;
    d_r <= d_nxt;     mu_r <= mu_nxt;
    dxm_r <= dxm_nxt; dym_r <= dym_nxt;
    dxneg_r <= dxneg_nxt; dyneg_r <= dyneg_nxt; dneg_r <= dneg_nxt;
    tmp_r <= tmp_nxt; mag_r <= mag_nxt; m_r <= m_nxt;
    dmag_r <= dmag_nxt; mxm_r <= mxm_nxt; mym_r <= mym_nxt;
  end

  `ASSERT_SAME(a_start_idle, clk, rst_n, alu_req.start, !alu_rsp.busy, "start while unit busy")
  `ASSERT_SAME(a_done_wait, clk, rst_n, alu_rsp.done, state_r == S_WAIT, "result outside wait")
  `ASSERT_SAME(a_wr_state, clk, rst_n, mem_we, (state_r == S_WR0) || (state_r == S_WA) || (state_r == S_WB), "stray memory write")
  `ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "second beat taken")
  `ASSERT_NEXT(a_out_load, clk, rst_n, (state_r == S_OUT) && (!out_valid_r || out_tready), out_tvalid, "result lost")

endmodule

// File: rtl/core/gls_store.sv
// ---------------------------------------------------------------------------
// gls_store
// Node coordinate memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module gls_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [gls_pkg::AW-1:0]    waddr,
  input  logic [gls_pkg::MEMW-1:0]  wdata,
  input  logic [gls_pkg::AW-1:0]    raddr,
  output logic [gls_pkg::MEMW-1:0]  rdata
);
  import gls_pkg::*;

  logic [MEMW-1:0] mem [NODE_DEPTH];
  logic [MEMW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/gls_alu.sv
// ---------------------------------------------------------------------------
// gls_alu
// Shared iterative unit: digit-serial multiply, bit-serial divide and root.
// ---------------------------------------------------------------------------
module gls_alu (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gls_pkg::alu_req_t        req,
  input  logic [gls_pkg::OPW-1:0]  opa,
  input  logic [gls_pkg::OPW-1:0]  opb,
  input  logic [gls_pkg::PW-1:0]   num,
  input  logic [gls_pkg::OPW-1:0]  den,
  output gls_pkg::alu_rsp_t        rsp,
  output logic [gls_pkg::PW-1:0]   res
);
  import gls_pkg::*;

  alu_op_t         op_r, op_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]   acc_r, acc_nxt;
  logic [BW-1:0]   mb_r, mb_nxt;
  logic [OPW-1:0]  ma_r, ma_nxt;
  logic [SRW-1:0]  rem_r, rem_nxt;
  logic [OPW-1:0]  root_r, root_nxt;

  logic [OPW+DIGW-1:0] pp;
  logic [SRW-1:0]      dsh;
  logic [SRW-1:0]      ssh;
  logic [SRW-1:0]      trial;
  logic [SRW+PW-1:0]   wide_mu;
  logic [SRW+PW-1:0]   wide_co;

  assign pp      = ma_r * mb_r[BW-1 -: DIGW];
  assign dsh     = {rem_r[SRW-2:0], acc_r[PW-1]};
  assign ssh     = {rem_r[SRW-3:0], acc_r[PW-1 -: 2]};
  assign trial   = SRW'({root_r, 2'b01});
  assign wide_mu = {{SRW{1'b0}}, num} << (PW - MUQW);
  assign wide_co = {{SRW{1'b0}}, num} << (PW - QW);

  always_comb begin
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mb_nxt   = mb_r;
    ma_nxt   = ma_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (req.start && !busy_r) begin
      op_nxt   = req.op;
      busy_nxt = 1'b1;
      unique case (req.op)
        ALU_MUL: begin
          acc_nxt = '0;
          ma_nxt  = opa;
          mb_nxt  = BW'(opb);
          cnt_nxt = CNTW'(MD);
        end
        ALU_DIV_MU: begin
          acc_nxt = wide_mu[PW-1:0];
          rem_nxt = wide_mu[PW +: SRW];
          ma_nxt  = den;
          cnt_nxt = CNTW'(MUQW);
        end
        ALU_DIV_CO: begin
          acc_nxt = wide_co[PW-1:0];
          rem_nxt = wide_co[PW +: SRW];
          ma_nxt  = den;
          cnt_nxt = CNTW'(QW);
        end
        ALU_SQRT: begin
          acc_nxt  = num;
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = CNTW'(OPW);
        end
        default: begin
          cnt_nxt = CNTW'(1);
        end
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        ALU_MUL: begin
          acc_nxt = {acc_r[PW-DIGW-1:0], {DIGW{1'b0}}} + PW'(pp);
          mb_nxt  = {mb_r[BW-DIGW-1:0], {DIGW{1'b0}}};
        end
        ALU_DIV_MU, ALU_DIV_CO: begin
          if (dsh >= SRW'(ma_r)) begin
            rem_nxt = dsh - SRW'(ma_r);
            acc_nxt = {acc_r[PW-2:0], 1'b1};
          end else begin
            rem_nxt = dsh;
            acc_nxt = {acc_r[PW-2:0], 1'b0};
          end
        end
        ALU_SQRT: begin
          acc_nxt = {acc_r[PW-3:0], 2'b00};
          if (ssh >= trial) begin
            rem_nxt  = ssh - trial;
            root_nxt = {root_r[OPW-2:0], 1'b1};
          end else begin
            rem_nxt  = ssh;
            root_nxt = {root_r[OPW-2:0], 1'b0};
          end
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    mb_r   <= mb_nxt;
    ma_r   <= ma_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign res      = (op_r == ALU_SQRT) ? PW'(root_r) : acc_r;

endmodule

// File: tb/tb_graph_layout_sgd_pair_update.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_graph_layout_sgd_pair_update
// Drives write, read and pair-update beats into the SGD pair-update engine
// with bursty input and a stalling output. A predictor keeps its own node
// table and works out the coordinates returned for every accepted beat.
// ---------------------------------------------------------------------------
module tb_graph_layout_sgd_pair_update;
  import gls_pkg::*;

  localparam logic [MODEW-1:0] MODE_READ = 2'd2;
  localparam logic [MODEW-1:0] MODE_ALT  = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam longint CMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (COORD_WIDTH - 1));

  typedef struct packed {
    coord_t yb;
    coord_t xb;
    coord_t ya;
    coord_t xa;
  } quad_t;

  class pair_scoreboard;
    coord_t xs[NODE_DEPTH];
    coord_t ys[NODE_DEPTH];
    quad_t  coords_due[$];
    int     errors;

    function automatic coord_t clamp(input logic signed [66:0] s);
      if (s > CMAX) return coord_t'(CMAX);
      if (s < CMIN) return coord_t'(CMIN);
      return coord_t'(s);
    endfunction

    function automatic logic [63:0] root(input logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
        c = r | (64'd1 << i);
        if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
    endfunction

    function automatic logic [63:0] quot(input logic [127:0] n, input logic [63:0] dv);
      logic [127:0] q;
      q = n / {64'd0, dv};
      return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic void move_pair(input int a, input int b, input logic [31:0] pa,
                                      input logic [31:0] pb, input logic [39:0] eta);
      logic signed [63:0] xa, ya, xb, yb, mx, my;
      logic signed [64:0] t;
      logic [63:0] d, mu, dxm, dym, mag, bigd, m, dmag, mxm, mym;
      logic [127:0] p, sum;
      logic dxneg, dyneg, dneg;
      xa = 64'(xs[a]); ya = 64'(ys[a]); xb = 64'(xs[b]); yb = 64'(ys[b]);
      d = (pa >= pb) ? 64'(pa - pb) : 64'(pb - pa);
      if (d == 0 || {24'd0, eta} >= (d << 8)) mu = 64'd1 << 32;
      else mu = ({24'd0, eta} << 24) / d;
      dxneg = xa < xb;
      dyneg = ya < yb;
      t = 65'(xa) - 65'(xb); dxm = t[64] ? 64'(-t) : 64'(t);
      t = 65'(ya) - 65'(yb); dym = t[64] ? 64'(-t) : 64'(t);
      if (dxm == 0) begin
        dxm = 1;
        dxneg = 1'b0;
      end
      sum = {64'd0, dxm} * {64'd0, dxm} + {64'd0, dym} * {64'd0, dym};
      mag = root(sum);
      bigd = d << 16;
      dneg = mag < bigd;
      m = dneg ? bigd - mag : mag - bigd;
      p = {64'd0, mu} * {64'd0, m};
      dmag = p[96:33];
      mxm = quot({64'd0, dmag} * {64'd0, dxm}, mag);
      mym = quot({64'd0, dmag} * {64'd0, dym}, mag);
      mx = (dneg != dxneg) ? -$signed(mxm) : $signed(mxm);
      my = (dneg != dyneg) ? -$signed(mym) : $signed(mym);
      xs[a] = clamp(67'(xa) - 67'(mx));
      ys[a] = clamp(67'(ya) - 67'(my));
      xs[b] = clamp(67'(xb) + 67'(mx));
      ys[b] = clamp(67'(yb) + 67'(my));
    endfunction

    function automatic void note_beat(input logic [MODEW-1:0] mode,
                                      input logic [ITW-1:0] dat);
      int a, b;
      quad_t q;
      a = int'(dat[IDW-1:0]);
      b = int'(dat[OFF_NB +: IDW]);
      if (mode == MODE_WRITE) begin
        xs[a] = dat[OFF_XIN +: COORD_WIDTH];
        ys[a] = dat[OFF_YIN +: COORD_WIDTH];
      end else if (mode == MODE_UPDATE) begin
        move_pair(a, b, dat[OFF_PA +: POSW], dat[OFF_PB +: POSW], dat[OFF_ETA +: ETAW]);
      end
      q.xa = xs[a]; q.ya = ys[a]; q.xb = xs[b]; q.yb = ys[b];
      coords_due = {coords_due, q};
    endfunction

    function automatic void check_beat(input logic [OTW-1:0] dat);
      quad_t e, g;
      g = dat[4*COORD_WIDTH-1:0];
      if (coords_due.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, dat);
        errors++;
        return;
      end
      e = coords_due.pop_front();
      if (g.xa !== e.xa) begin
        $display("%0t: x_a expected %0d actual %0d", $realtime, e.xa, g.xa); errors++;
      end
      if (g.ya !== e.ya) begin
        $display("%0t: y_a expected %0d actual %0d", $realtime, e.ya, g.ya); errors++;
      end
      if (g.xb !== e.xb) begin
        $display("%0t: x_b expected %0d actual %0d", $realtime, e.xb, g.xb); errors++;
      end
      if (g.yb !== e.yb) begin
        $display("%0t: y_b expected %0d actual %0d", $realtime, e.yb, g.yb); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ITW-1:0] in_tdata = '0;   // node_a, node_b, pos_a, pos_b, eta, x_in, y_in
  logic [MODEW-1:0] in_tuser = '0; // mode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OTW-1:0] out_tdata;       // x_a, y_a, x_b, y_b

  pair_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int written[$];
  bit is_written[NODE_DEPTH];

  graph_layout_sgd_pair_update DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: alternate calm and stalling stretches, with one long hold-off
  always @(posedge clk) begin
    if (cycles >= 20000 && cycles < 24000) begin
      out_tready <= 1'b0;
    end else if ((cycles / 700) % 3 == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata);
  end

  task automatic send_beat(input logic [MODEW-1:0] mode, input int a, input int b,
                           input logic [31:0] pa, input logic [31:0] pb,
                           input logic [39:0] eta, input coord_t x, input coord_t y);
    logic [ITW-1:0] dat;
    int gap;
    dat = '0;
    dat[IDW-1:0] = IDW'(a);
    dat[OFF_NB +: IDW] = IDW'(b);
    dat[OFF_PA +: POSW] = pa;
    dat[OFF_PB +: POSW] = pb;
    dat[OFF_ETA +: ETAW] = eta;
    dat[OFF_XIN +: COORD_WIDTH] = x;
    dat[OFF_YIN +: COORD_WIDTH] = y;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= dat;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(mode, dat);
    burst_left--;
    if (mode == MODE_WRITE && !is_written[a]) begin
      is_written[a] = 1'b1;
      written = {written, a};
    end
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'({$urandom, $urandom});
      1: return coord_t'(CMAX);
      2: return coord_t'(CMIN);
      default: return coord_t'($signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000);
    endcase
  endfunction

  function automatic int pick_node();
    return written[$urandom_range(0, written.size() - 1)];
  endfunction

  initial begin
    int a, b, sel;
    logic [31:0] pa, pb;
    logic [39:0] eta;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, every mode, equal ids, zero dx, zero distance
    send_beat(MODE_WRITE, 0, 0, 0, 0, 0, coord_t'(CMAX), coord_t'(CMIN));
    send_beat(MODE_WRITE, 1023, 0, '1, '1, '1, coord_t'(CMIN), coord_t'(CMAX));
    send_beat(MODE_WRITE, 5, 1023, 0, 0, 0, 48'sd65536, 48'sd0);
    send_beat(MODE_WRITE, 6, 0, 0, 0, 0, 48'sd65536, 48'sd3000000);
    send_beat(MODE_WRITE, 682, 0, 0, 0, 0, -48'sd1, 48'sd1);
    send_beat(MODE_WRITE, 341, 682, 0, 0, 0, 48'sd1000, -48'sd700000);
    send_beat(MODE_READ, 0, 1023, 0, 0, 0, 0, 0);
    send_beat(MODE_ALT, 5, 6, 0, 0, 0, 0, 0);
    send_beat(MODE_UPDATE, 0, 1023, 0, 32'hFFFFFFFF, 0, 0, 0);
    send_beat(MODE_UPDATE, 0, 1023, 32'hFFFFFFFF, 0, '1, 0, 0);
    send_beat(MODE_UPDATE, 5, 6, 100, 100, 40'd256, 0, 0);
    send_beat(MODE_UPDATE, 5, 6, 10, 90, 40'd50, 0, 0);
    send_beat(MODE_UPDATE, 6, 6, 3, 9, 40'd1000, 0, 0);
    send_beat(MODE_UPDATE, 682, 341, 1, 2, '1, 0, 0);
    send_beat(MODE_UPDATE, 341, 682, 7, 7, 0, 0, 0);
    send_beat(MODE_UPDATE, 1023, 5, 0, 1, 40'd1, 0, 0);
    send_beat(MODE_READ, 682, 6, 0, 0, 0, 0, 0);
    send_beat(MODE_ALT, 1023, 341, 0, 0, 0, 0, 0);
    // random: mostly updates on written nodes, some writes and reads
    repeat (1000) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        a = (sel < 8 || written.size() < 40) ? $urandom_range(0, 1023) : pick_node();
        send_beat(MODE_WRITE, a, pick_node(), $urandom, $urandom,
                  40'({$urandom, $urandom}), rand_coord(), rand_coord());
      end else if (sel < 30) begin
        send_beat(sel[0] ? MODE_READ : MODE_ALT, pick_node(), pick_node(), $urandom,
                  $urandom, 40'({$urandom, $urandom}), rand_coord(), rand_coord());
      end else begin
        a = pick_node();
        b = ($urandom_range(0, 19) == 0) ? a : pick_node();
        pa = $urandom;
        pb = ($urandom_range(0, 3) == 0) ? $urandom : pa + $urandom_range(0, 2000) - 1000;
        eta = ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom}) :
              40'($urandom_range(0, 65536));
        send_beat(MODE_UPDATE, a, b, pa, pb, eta, rand_coord(), rand_coord());
      end
    end
    in_tvalid <= 1'b0;
    while (sb.coords_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.coords_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
